FILE: rtl/psd_pkg.sv
// Shared types, constants and helpers for the point to segment distance block.
// No dependencies; every other file in rtl/ imports this package.
package psd_pkg;

  localparam int FIELD_W       = 16;   // width of coordinate fields
  localparam int DIFF_W        = 17;   // coordinate differences
  localparam int PROD_W        = 34;   // 17x17 signed products
  localparam int SUM_W         = 36;   // sum of three products
  localparam int CROSS_W       = 35;   // cross product components
  localparam int DIST_W        = 34;   // squared distance and result
  localparam int ROOT_W        = 17;   // integer root of a DIST_W value
  localparam int NUM_W         = 70;   // sum of three squared cross terms
  localparam int QUEUE_DEPTH   = 4;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT    = 3'd6;

  localparam logic [1:0] REGION_START    = 2'd0;
  localparam logic [1:0] REGION_END      = 2'd1;
  localparam logic [1:0] REGION_INTERIOR = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
  } seg_t;

  // One classified item on its way from front to back.
  typedef struct packed {
    logic [1:0]                  region;
    logic [DIST_W-1:0]           sq;    // endpoint squared distance
    logic [DIST_W-1:0]           den;   // |AB|^2
    logic [2:0][DIST_W-1:0]      mag;   // |AB x AC| components
  } item_t;

  // Sign-extend from the low eff bits.
  function automatic logic signed [FIELD_W-1:0] sext(input logic [FIELD_W-1:0] v,
                                                     input int unsigned eff);
    logic [FIELD_W-1:0] r;
    for (int i = 0; i < FIELD_W; i++) begin
      r[i] = (i < eff) ? v[i] : v[eff-1];
    end
    return signed'(r);
  endfunction

endpackage

FILE: rtl/psd_queue.sv
// Small flop-based FIFO between the front and back halves.
// Depends on psd_pkg for item_t and QUEUE_DEPTH.
module psd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psd_pkg::item_t  din,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output psd_pkg::item_t  dout
);
  import psd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign dout     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/psd_front.sv
// Front half: differences, dot and cross products, region classification.
// Depends on psd_pkg; feeds psd_queue.
module psd_front #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  psd_pkg::seg_t                        seg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [psd_pkg::FIELD_W-1:0]   point_x,
  input  logic signed [psd_pkg::FIELD_W-1:0]   point_y,
  input  logic signed [psd_pkg::FIELD_W-1:0]   point_z,
  input  logic                                 q_full,
  output logic                                 push,
  output psd_pkg::item_t                       push_item
);
  import psd_pkg::*;

  localparam int unsigned EFF_W = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;

  logic adv;
  logic v1, v2, v3;

  logic signed [FIELD_W-1:0] a [3];
  logic signed [FIELD_W-1:0] b [3];
  logic signed [FIELD_W-1:0] c [3];

  logic signed [DIFF_W-1:0] ab [3];
  logic signed [DIFF_W-1:0] ac [3];
  logic signed [DIFF_W-1:0] bc [3];

  logic signed [PROD_W-1:0] p_abac [3];
  logic signed [PROD_W-1:0] p_abbc [3];
  logic signed [PROD_W-1:0] p_abab [3];
  logic signed [PROD_W-1:0] p_acac [3];
  logic signed [PROD_W-1:0] p_bcbc [3];
  logic signed [PROD_W-1:0] p_x    [3];
  logic signed [PROD_W-1:0] p_y    [3];

  logic signed [SUM_W-1:0]   dac, dbc, len, sqa, sqb;
  logic signed [CROSS_W-1:0] cr [3];

  assign a[0] = sext(seg.ax, EFF_W);
  assign a[1] = sext(seg.ay, EFF_W);
  assign a[2] = sext(seg.az, EFF_W);
  assign b[0] = sext(seg.bx, EFF_W);
  assign b[1] = sext(seg.by, EFF_W);
  assign b[2] = sext(seg.bz, EFF_W);
  assign c[0] = sext(point_x, EFF_W);
  assign c[1] = sext(point_y, EFF_W);
  assign c[2] = sext(point_z, EFF_W);

  // global stall: the whole front holds while its last stage waits on the queue
  assign adv      = !v3 || !q_full;
  assign in_ready = adv;
  assign push     = v3 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      if (adv) begin
        ab[i]     <= DIFF_W'(b[i]) - DIFF_W'(a[i]);
        ac[i]     <= DIFF_W'(c[i]) - DIFF_W'(a[i]);
        bc[i]     <= DIFF_W'(c[i]) - DIFF_W'(b[i]);
        p_abac[i] <= ab[i] * ac[i];
        p_abbc[i] <= ab[i] * bc[i];
        p_abab[i] <= ab[i] * ab[i];
        p_acac[i] <= ac[i] * ac[i];
        p_bcbc[i] <= bc[i] * bc[i];
        p_x[i]    <= ab[J] * ac[K];
        p_y[i]    <= ab[K] * ac[J];
        cr[i]     <= CROSS_W'(p_x[i]) - CROSS_W'(p_y[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dac <= SUM_W'(p_abac[0]) + SUM_W'(p_abac[1]) + SUM_W'(p_abac[2]);
      dbc <= SUM_W'(p_abbc[0]) + SUM_W'(p_abbc[1]) + SUM_W'(p_abbc[2]);
      len <= SUM_W'(p_abab[0]) + SUM_W'(p_abab[1]) + SUM_W'(p_abab[2]);
      sqa <= SUM_W'(p_acac[0]) + SUM_W'(p_acac[1]) + SUM_W'(p_acac[2]);
      sqb <= SUM_W'(p_bcbc[0]) + SUM_W'(p_bcbc[1]) + SUM_W'(p_bcbc[2]);
    end
  end

  // classify; a zero-length segment is the start case, else ties on either dot product fall to the interior case
  always_comb begin
    push_item.den = len[DIST_W-1:0];
    for (int i = 0; i < 3; i++) begin
      push_item.mag[i] = cr[i][CROSS_W-1] ? DIST_W'(-cr[i]) : DIST_W'(cr[i]);
    end
    if (len == '0 || dac < 0) begin
      push_item.region = REGION_START;
      push_item.sq     = sqa[DIST_W-1:0];
    end else if (dbc > 0) begin
      push_item.region = REGION_END;
      push_item.sq     = sqb[DIST_W-1:0];
    end else begin
      push_item.region = REGION_INTERIOR;
      push_item.sq     = sqa[DIST_W-1:0];
    end
  end

endmodule

FILE: rtl/psd_back.sv
// Back half: squared cross magnitude, pipelined divider, pipelined square root.
// Depends on psd_pkg; drains psd_queue and drives the result channel.
module psd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          root_mode,
  input  logic                          q_valid,
  input  psd_pkg::item_t                q_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [psd_pkg::DIST_W-1:0]    distance,
  output logic [1:0]                    region
);
  import psd_pkg::*;

  localparam int HALF_W   = DIST_W / 2;
  localparam int SQR_W    = 2 * DIST_W;
  localparam int DIV_N    = DIST_W;
  localparam int SQ_N     = ROOT_W;
  localparam int STAGES   = 3 + DIV_N + SQ_N;
  localparam int SREM_W   = ROOT_W + 4;

  typedef struct packed {
    logic [1:0]        region;
    logic [DIST_W-1:0] sq;
    logic [DIST_W-1:0] den;
  } meta_t;

  logic              adv;
  logic [STAGES-1:0] vld;

  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[STAGES-2:0], q_valid};
      out_valid <= vld[STAGES-1];
    end
  end

  // stage 1 to 3: |cr|^2 summed, each 34-bit magnitude split into 17-bit halves
  meta_t            m1, m2, m3;
  logic [DIST_W-1:0] hh [3];
  logic [DIST_W-1:0] hl [3];
  logic [DIST_W-1:0] ll [3];
  logic [SQR_W-1:0]  sqr [3];
  logic [NUM_W-1:0]  num;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        hh[i]  <= q_item.mag[i][DIST_W-1:HALF_W] * q_item.mag[i][DIST_W-1:HALF_W];
        hl[i]  <= q_item.mag[i][DIST_W-1:HALF_W] * q_item.mag[i][HALF_W-1:0];
        ll[i]  <= q_item.mag[i][HALF_W-1:0] * q_item.mag[i][HALF_W-1:0];
        sqr[i] <= (SQR_W'(hh[i]) << DIST_W) + (SQR_W'(hl[i]) << (HALF_W + 1))
                + SQR_W'(ll[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1  <= '{region: q_item.region, sq: q_item.sq, den: q_item.den};
      m2  <= m1;
      m3  <= m2;
      num <= NUM_W'(sqr[0]) + NUM_W'(sqr[1]) + NUM_W'(sqr[2]);
    end
  end

  // restoring divider, one quotient bit per stage; quotient never exceeds
  // the start-point distance, so the high half of num is below den
  logic [DIST_W-1:0] d_rem [DIV_N];
  logic [DIST_W-1:0] d_lo  [DIV_N];
  logic [DIST_W-1:0] d_q   [DIV_N];
  meta_t             d_m   [DIV_N];

  for (genvar s = 0; s < DIV_N; s++) begin : g_div
    logic [DIST_W-1:0] rem_in, lo_in, q_in;
    meta_t             m_in;
    logic [DIST_W:0]   sh;
    if (s == 0) begin : g_first
      assign rem_in = num[2*DIST_W-1:DIST_W];
      assign lo_in  = num[DIST_W-1:0];
      assign q_in   = '0;
      assign m_in   = m3;
    end else begin : g_next
      assign rem_in = d_rem[s-1];
      assign lo_in  = d_lo[s-1];
      assign q_in   = d_q[s-1];
      assign m_in   = d_m[s-1];
    end
    assign sh = {rem_in, lo_in[DIST_W-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        d_lo[s] <= {lo_in[DIST_W-2:0], 1'b0};
        d_m[s]  <= m_in;
        if (sh >= {1'b0, m_in.den}) begin
          d_rem[s] <= DIST_W'(sh - {1'b0, m_in.den});
          d_q[s]   <= {q_in[DIST_W-2:0], 1'b1};
        end else begin
          d_rem[s] <= sh[DIST_W-1:0];
          d_q[s]   <= {q_in[DIST_W-2:0], 1'b0};
        end
      end
    end
  end

  // digit-by-digit integer square root, two radicand bits per stage
  logic [DIST_W-1:0] sel_val;
  logic [SREM_W-1:0] s_rem  [SQ_N];
  logic [ROOT_W-1:0] s_root [SQ_N];
  logic [DIST_W-1:0] s_v    [SQ_N];
  logic [DIST_W-1:0] s_val  [SQ_N];
  logic [1:0]        s_reg  [SQ_N];

  assign sel_val = (d_m[DIV_N-1].region == REGION_INTERIOR) ? d_q[DIV_N-1]
                                                            : d_m[DIV_N-1].sq;

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [SREM_W-1:0] rem_in, sh, t;
    logic [ROOT_W-1:0] root_in;
    logic [DIST_W-1:0] v_in, val_in;
    logic [1:0]        reg_in;
    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = sel_val;
      assign val_in  = sel_val;
      assign reg_in  = d_m[DIV_N-1].region;
    end else begin : g_next
      assign rem_in  = s_rem[j-1];
      assign root_in = s_root[j-1];
      assign v_in    = s_v[j-1];
      assign val_in  = s_val[j-1];
      assign reg_in  = s_reg[j-1];
    end
    assign sh = {rem_in[SREM_W-3:0], v_in[DIST_W-1:DIST_W-2]};
    assign t  = SREM_W'({root_in, 2'b01});
    always_ff @(posedge clk) begin
      if (adv) begin
        s_v[j]   <= {v_in[DIST_W-3:0], 2'b00};
        s_val[j] <= val_in;
        s_reg[j] <= reg_in;
        if (sh >= t) begin
          s_rem[j]  <= sh - t;
          s_root[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          s_rem[j]  <= sh;
          s_root[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      distance <= root_mode ? DIST_W'(s_root[SQ_N-1]) : s_val[SQ_N-1];
      region   <= s_reg[SQ_N-1];
    end
  end

endmodule

FILE: rtl/point_segment_distance.sv
// Point to segment distance, 3D, signed fixed point coordinates.
// Throughput: one item per cycle while out_ready stays high, sustained by the
// pipelined divider and root.
// Reset: synchronous, active high; clears all valid state and the registers
// to zero (segment collapsed at the origin, squared-distance mode).
module point_segment_distance #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [psd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psd_pkg::FIELD_W-1:0]         cfg_data,
  // query points
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [psd_pkg::FIELD_W-1:0]  point_x,
  input  logic signed [psd_pkg::FIELD_W-1:0]  point_y,
  input  logic signed [psd_pkg::FIELD_W-1:0]  point_z,
  // results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psd_pkg::DIST_W-1:0]          distance,
  output logic [1:0]                          region
);
  import psd_pkg::*;

  seg_t  seg;
  logic  root_mode;
  logic  q_full, q_nonempty, push, pop;
  item_t push_item, q_item;

  // Register writes always taken; write only while the block is idle (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg       <= '0;
      root_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_X: seg.ax    <= cfg_data;
        REG_START_Y: seg.ay    <= cfg_data;
        REG_START_Z: seg.az    <= cfg_data;
        REG_END_X:   seg.bx    <= cfg_data;
        REG_END_Y:   seg.by    <= cfg_data;
        REG_END_Z:   seg.bz    <= cfg_data;
        REG_ROOT:    root_mode <= cfg_data[0];
        default:     root_mode <= root_mode;  // drop writes past the list
      endcase
    end
  end

  // Front: differences, products and classification; stalls only on a full queue.
  psd_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk,
    .rst,
    .seg,
    .in_valid,
    .in_ready,
    .point_x,
    .point_y,
    .point_z,
    .q_full,
    .push,
    .push_item
  );

  // Queue decouples the front from back-pressure on the result channel.
  psd_queue u_queue (
    .clk,
    .rst,
    .push,
    .din(push_item),
    .full(q_full),
    .pop,
    .nonempty(q_nonempty),
    .dout(q_item)
  );

  // Back: perpendicular division and optional root; holds while a result waits with out_ready low.
  psd_back u_back (
    .clk,
    .rst,
    .root_mode,
    .q_valid(q_nonempty),
    .q_item,
    .pop,
    .out_valid,
    .out_ready,
    .distance,
    .region
  );

endmodule

FILE: rtl/psd_checker.sv
// Port-level checks for point_segment_distance, bound to the top level.
// Depends on psd_pkg for widths and region codes.
module psd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [psd_pkg::DIST_W-1:0]   distance,
  input logic [1:0]                   region
);
  import psd_pkg::*;

  a_region_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (region == REGION_START || region == REGION_END ||
                   region == REGION_INTERIOR))
    else $error("region code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(region))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk,
  .rst,
  .in_ready,
  .out_valid,
  .out_ready,
  .distance,
  .region
);

FILE: sim/tb_point_segment_distance.sv
// Testbench for point_segment_distance: directed table then random query points,
// each result checked against a typed-in value or an in-bench predictor. Depends on psd_pkg.
`timescale 1ns / 1ps

module tb_point_segment_distance;
  import psd_pkg::*;

  localparam int LATENCY   = 58;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 1300;
  localparam logic [1:0] RG_NONE = 2'd3;   // table row: no typed-in region

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [FIELD_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] distance;
  logic [1:0] region;

  point_segment_distance dut (.*);

  always #4 clk = ~clk;

  // Segment and mode as the bench believes the block holds them.
  logic signed [FIELD_W-1:0] seg [6];
  logic root_on;

  typedef struct {
    logic [DIST_W-1:0] dval;
    logic [1:0] rg;
  } dist_res_t;

  dist_res_t pending_dist[$];
  int errors = 0;
  int cycles = 0;
  bit rx_stall_on = 1'b1;

  // Floor square root, bit by bit.
  function automatic logic [DIST_W-1:0] floor_root(input logic [DIST_W-1:0] v);
    logic [DIST_W-1:0] r;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      logic [DIST_W-1:0] t;
      t = r | (34'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic dist_res_t predict_dist(input logic signed [FIELD_W-1:0] px,
      input logic signed [FIELD_W-1:0] py, input logic signed [FIELD_W-1:0] pz);
    longint ab[3], ac[3], bc[3], cr[3], len, d1, d2;
    logic [127:0] num;
    logic [127:0] q;
    logic [DIST_W-1:0] sq;
    dist_res_t r;
    ab[0] = seg[3] - seg[0]; ab[1] = seg[4] - seg[1]; ab[2] = seg[5] - seg[2];
    ac[0] = px - seg[0]; ac[1] = py - seg[1]; ac[2] = pz - seg[2];
    bc[0] = px - seg[3]; bc[1] = py - seg[4]; bc[2] = pz - seg[5];
    len = ab[0]*ab[0] + ab[1]*ab[1] + ab[2]*ab[2];
    d1 = ab[0]*ac[0] + ab[1]*ac[1] + ab[2]*ac[2];
    d2 = ab[0]*bc[0] + ab[1]*bc[1] + ab[2]*bc[2];
    if (len == 0 || d1 < 0) begin
      r.rg = REGION_START;
      sq = DIST_W'(ac[0]*ac[0] + ac[1]*ac[1] + ac[2]*ac[2]);
    end else if (d2 > 0) begin
      r.rg = REGION_END;
      sq = DIST_W'(bc[0]*bc[0] + bc[1]*bc[1] + bc[2]*bc[2]);
    end else begin
      r.rg = REGION_INTERIOR;
      cr[0] = ab[1]*ac[2] - ab[2]*ac[1];
      cr[1] = ab[2]*ac[0] - ab[0]*ac[2];
      cr[2] = ab[0]*ac[1] - ab[1]*ac[0];
      num = 0;
      for (int i = 0; i < 3; i++) begin
        logic [127:0] m;
        m = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
        num += m * m;
      end
      q = num / 128'(len);
      sq = (q > 128'h3_FFFF_FFFF) ? {DIST_W{1'b1}} : q[DIST_W-1:0];
    end
    r.dval = root_on ? floor_root(sq) : sq;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: optional random stall; each accepted item checked against the oldest.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= rx_stall_on ? ($urandom_range(0, 9) > 2) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_dist.size() == 0) begin
        $display("%0t: unexpected result distance=%0d region=%0d", $time, distance, region);
        errors++;
      end else begin
        dist_res_t e;
        e = pending_dist.pop_front();
        if (distance !== e.dval) begin
          $display("%0t: distance expected %0d actual %0d", $time, e.dval, distance);
          errors++;
        end
        if (region !== e.rg) begin
          $display("%0t: region expected %0d actual %0d", $time, e.rg, region);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROOT) root_on = val[0];
    else seg[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_segment(input logic [FIELD_W-1:0] ax, input logic [FIELD_W-1:0] ay,
      input logic [FIELD_W-1:0] az, input logic [FIELD_W-1:0] bx,
      input logic [FIELD_W-1:0] by, input logic [FIELD_W-1:0] bz, input logic rm);
    write_reg(REG_START_X, ax); write_reg(REG_START_Y, ay); write_reg(REG_START_Z, az);
    write_reg(REG_END_X, bx);   write_reg(REG_END_Y, by);   write_reg(REG_END_Z, bz);
    write_reg(REG_ROOT, {15'd0, rm});
  endtask

  // Hold valid and payload until the item is accepted; idle only between items.
  task automatic send_point(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
      input logic [FIELD_W-1:0] z, input logic [DIST_W-1:0] typed_dist,
      input logic [1:0] typed_rg);
    dist_res_t e;
    int g;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    point_x <= x; point_y <= y; point_z <= z;
    e = predict_dist(x, y, z);
    if (typed_rg != RG_NONE) begin
      e.dval = typed_dist;
      e.rg = typed_rg;
    end
    do @(posedge clk); while (!in_ready);
    pending_dist.push_back(e);
  endtask

  // Drop valid and let every pending item drain before a register write.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] rand_coord(input bit narrow);
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return narrow ? 16'($signed($urandom_range(0, 2047)) - 1024) : 16'($urandom);
    endcase
  endfunction

  typedef struct {
    logic [FIELD_W-1:0] x, y, z;
    logic [DIST_W-1:0] dval;
    logic [1:0] rg;
  } point_row_t;

  // Directed rows; expected value typed in where it is obvious.
  point_row_t pts_origin[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 34'd0, REGION_START},
    '{16'h0100, 16'h0000, 16'h0000, 34'd65536, REGION_START},
    '{16'h8000, 16'h8000, 16'h8000, 34'd3221225472, REGION_START},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 34'd3221028867, REGION_START},
    '{16'h8000, 16'h7FFF, 16'h0000, 34'd2147418113, REGION_START}
  };
  point_row_t pts_seg[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 34'd0, RG_NONE},   // on start
    '{16'h0400, 16'h0000, 16'h0000, 34'd0, RG_NONE},   // on end
    '{16'h0200, 16'h0300, 16'h0000, 34'd0, RG_NONE},   // interior
    '{16'hFF00, 16'h0100, 16'h0000, 34'd0, RG_NONE},   // beyond start
    '{16'h0500, 16'h0000, 16'h0100, 34'd0, RG_NONE},   // beyond end
    '{16'h0000, 16'h0700, 16'h0000, 34'd0, RG_NONE},   // tie at start
    '{16'h0400, 16'h8000, 16'h7FFF, 34'd0, RG_NONE},   // tie at end
    '{16'h7FFF, 16'h8000, 16'h7FFF, 34'd0, RG_NONE},
    '{16'h8000, 16'h7FFF, 16'h8000, 34'd0, RG_NONE},
    '{16'h0123, 16'hFEDC, 16'h5555, 34'd0, RG_NONE}
  };

  initial begin
    int n_got;
    for (int i = 0; i < 6; i++) seg[i] = '0;
    root_on = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset: degenerate segment at the origin, squared mode.
    foreach (pts_origin[i])
      send_point(pts_origin[i].x, pts_origin[i].y, pts_origin[i].z,
                 pts_origin[i].dval, pts_origin[i].rg);
    drain();

    for (int m = 0; m < 2; m++) begin
      load_segment(16'h0000, 16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, m[0]);
      foreach (pts_seg[i])
        send_point(pts_seg[i].x, pts_seg[i].y, pts_seg[i].z, 34'd0, RG_NONE);
      drain();
    end

    // Extreme segment corner to corner, root mode.
    load_segment(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_point(16'h7FFF, 16'h8000, 16'h0000, 34'd0, RG_NONE);
    send_point(16'h8000, 16'h7FFF, 16'h7FFF, 34'd0, RG_NONE);
    drain();

    // Random phases: new segment and mode each phase, a stretch without stalls.
    n_got = 0;
    for (int ph = 0; n_got < N_RANDOM; ph++) begin
      bit narrow;
      logic [FIELD_W-1:0] sx, sy, sz;
      narrow = 1'($urandom_range(0, 1));
      rx_stall_on = (ph % 4) != 3;
      sx = rand_coord(narrow);
      sy = rand_coord(narrow);
      sz = rand_coord(narrow);
      if (ph % 5 == 4)
        load_segment(sx, sy, sz, sx, sy, sz, 1'($urandom_range(0, 1)));   // degenerate
      else
        load_segment(sx, sy, sz,
                     rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
                     1'($urandom_range(0, 1)));
      repeat (100) begin
        send_point(rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
                   34'd0, RG_NONE);
        n_got++;
      end
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
